// ===== rtl/signed_int_to_base_digits_core_defines.svh =====
// Assertion macros shared by the checker of the signed integer to digits core.
`ifndef SIGNED_INT_TO_BASE_DIGITS_CORE_DEFINES_SVH
`define SIGNED_INT_TO_BASE_DIGITS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SITBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SITBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sitbd_pkg.sv =====
// Types, constants and helpers shared by the signed integer to digits core.
package sitbd_pkg;

  localparam int VAL_W     = 32;
  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int SYM_COUNT = 16;
  localparam int SYM_IDX_W = 4;
  localparam int SP_W      = 6;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_ERR   = 6'b000100,
    ST_SIGN  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  function automatic logic [CHAR_W-1:0] symbol_at(
    input logic [CFG_W-1:0]     lo,
    input logic [CFG_W-1:0]     hi,
    input logic [SYM_IDX_W-1:0] idx
  );
    logic [CFG_W-1:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

// ===== rtl/sitbd_divider.sv =====
// Radix division step: eight quotient bits of the magnitude per cycle.
module sitbd_divider (
  input  logic [sitbd_pkg::VAL_W-1:0] mag,
  input  logic [sitbd_pkg::LEN_W-1:0] rem,
  input  logic [sitbd_pkg::LEN_W-1:0] radix,
  output logic [sitbd_pkg::VAL_W-1:0] mag_next,
  output logic [sitbd_pkg::LEN_W-1:0] rem_next
);
  import sitbd_pkg::*;

  logic [LEN_W:0]   r;
  logic [VAL_W-1:0] m;
  logic             qbit;

  always_comb begin
    r = {1'b0, rem};
    m = mag;
    for (int k = 0; k < 8; k++) begin
      r = {r[LEN_W-1:0], m[VAL_W-1]};
      qbit = (r >= {1'b0, radix});
      if (qbit) begin
        r = r - {1'b0, radix};
      end
      m = {m[VAL_W-2:0], qbit};
    end
    mag_next = m;
    rem_next = r[LEN_W-1:0];
  end

endmodule

// ===== rtl/signed_int_to_base_digits_core.sv =====
// Top level of the signed integer to digits core: sequencer, registers and digit stack.
//
// A value is taken at a clock edge where start is high and busy is low. The
// block then raises busy and produces a run of characters on out_char, each
// one shown for a single cycle with strobe high. A negative value first gives
// a minus sign, then the digits of its magnitude follow, most significant
// first, each taken from the symbol table; last marks the final character.
// When the configured base is not usable, the run is a single item with
// base_error and last set and out_char zero.
// The base registers are written through wr_en, wr_index and wr_data; the user must
// write them only while the block is idle, which the block itself does not enforce.
// base_len is register 0, symbols 0 to 7 register 1 and symbols 8 to 15 register 2.
// In order: the value is taken, the symbol table is checked entry by entry up to
// base_len, a minus sign is given for a negative value, each digit is formed by
// repeated steps of the shared divider (eight quotient bits per cycle) and pushed on
// the digit stack, and the stack is then emitted; the divider sets the pace.
// Reset clears the base registers and the sequencer. The receiver cannot stall.
module signed_int_to_base_digits_core #(
  parameter int MAX_BASE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [sitbd_pkg::VAL_W-1:0] value,
  output logic                              busy,
  output logic                              strobe,
  output logic [sitbd_pkg::CHAR_W-1:0]      out_char,
  output logic                              last,
  output logic                              base_error,
  input  logic                              wr_en,
  input  logic [sitbd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [sitbd_pkg::CFG_W-1:0]       wr_data
);
  import sitbd_pkg::*;

  state_t               state;
  logic [LEN_W-1:0]     base_len;
  logic [CFG_W-1:0]     symbols_low;
  logic [CFG_W-1:0]     symbols_high;
  logic [SYM_IDX_W-1:0] idx;
  logic [VAL_W-1:0]     mag;
  logic [LEN_W-1:0]     rem;
  logic [1:0]           step;
  logic                 neg;
  logic [SP_W-1:0]      sp;
  logic [SYM_IDX_W-1:0] digits [32];

  logic [CHAR_W-1:0]    sym [SYM_COUNT];
  logic [VAL_W-1:0]     raw;
  logic [VAL_W-1:0]     div_mag;
  logic [LEN_W-1:0]     div_rem;
  logic                 len_bad;
  logic                 sym_bad;
  logic [SP_W-2:0]      sp_top;

  assign raw    = value;
  assign busy   = (state != ST_IDLE);
  assign sp_top = sp[SP_W-2:0] - 5'd1;

  always_comb begin
    for (int j = 0; j < SYM_COUNT; j++) begin
      sym[j] = symbol_at(symbols_low, symbols_high, SYM_IDX_W'(j));
    end
  end

  always_comb begin
    len_bad = (base_len < 5'd2) || (int'(base_len) > MAX_BASE)
              || (int'(base_len) > SYM_COUNT);
    sym_bad = (sym[idx] == 8'd0) || (sym[idx] == CHAR_PLUS) || (sym[idx] == CHAR_MINUS);
    for (int j = 0; j < SYM_COUNT; j++) begin
      if ((LEN_W'(j) > {1'b0, idx}) && (LEN_W'(j) < base_len) && (sym[j] == sym[idx])) begin
        sym_bad = 1'b1;
      end
    end
  end

  sitbd_divider u_div (
    .mag      (mag),
    .rem      (rem),
    .radix    (base_len),
    .mag_next (div_mag),
    .rem_next (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_len     <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
      strobe       <= 1'b0;
      sp           <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_BASE_LEN:     base_len     <= wr_data[LEN_W-1:0];
          REG_SYMBOLS_LOW:  symbols_low  <= wr_data;
          REG_SYMBOLS_HIGH: symbols_high <= wr_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          strobe <= 1'b0;
          if (start) begin
            mag   <= raw[VAL_W-1] ? (32'd0 - raw) : raw;
            neg   <= raw[VAL_W-1];
            idx   <= '0;
            sp    <= '0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          strobe <= 1'b0;
          if (len_bad || sym_bad) begin
            state <= ST_ERR;
          end else if ({1'b0, idx} == base_len - 5'd1) begin
            rem   <= '0;
            step  <= '0;
            state <= neg ? ST_SIGN : ST_DIV;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        ST_ERR: begin
          strobe     <= 1'b1;
          out_char   <= '0;
          last       <= 1'b1;
          base_error <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_SIGN: begin
          strobe     <= 1'b1;
          out_char   <= CHAR_MINUS;
          last       <= 1'b0;
          base_error <= 1'b0;
          state      <= ST_DIV;
        end
        ST_DIV: begin
          strobe <= 1'b0;
          mag    <= div_mag;
          rem    <= (step == 2'd3) ? '0 : div_rem;
          step   <= step + 2'd1;
          if (step == 2'd3) begin
            digits[sp[SP_W-2:0]] <= div_rem[SYM_IDX_W-1:0];
            sp <= sp + 6'd1;
            if (div_mag == '0) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          strobe     <= 1'b1;
          out_char   <= sym[digits[sp_top]];
          last       <= (sp == 6'd1);
          base_error <= 1'b0;
          sp         <= sp - 6'd1;
          if (sp == 6'd1) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sitbd_checker.sv =====
// Port-level checker for the signed integer to digits core and its bind.
`include "signed_int_to_base_digits_core_defines.svh"

module sitbd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         strobe,
  input logic [sitbd_pkg::CHAR_W-1:0] out_char,
  input logic                         last,
  input logic                         base_error
);
  import sitbd_pkg::*;

  `SITBD_ASSERT_NOW(a_err_is_last, clk, rst, strobe && base_error, last, "Error item is not last.")
  `SITBD_ASSERT_NOW(a_err_char_zero, clk, rst, strobe && base_error, out_char == '0, "Error item has a character.")
  `SITBD_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "Accepted item did not raise busy.")
  `SITBD_ASSERT_NOW(a_run_busy, clk, rst, strobe && !last, busy, "Block went idle inside a run.")

endmodule

bind signed_int_to_base_digits_core sitbd_checker u_sitbd_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .out_char   (out_char),
  .last       (last),
  .base_error (base_error)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for signed_int_to_base_digits_core: directed table, then random phases.
module testbench;
  import sitbd_pkg::*;

  localparam int MAX_BASE    = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 25;

  localparam logic [CFG_W-1:0] DEC_LO = 64'h3736_3534_3332_3130;
  localparam logic [CFG_W-1:0] DEC_HI = 64'h0000_0000_0000_3938;
  localparam logic [CFG_W-1:0] HEX_HI = 64'h4645_4443_4241_3938;
  localparam logic [CFG_W-1:0] BIN_LO = 64'h0000_0000_0000_3130;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              err;
  } char_item_t;

  typedef enum int {CHK_MODEL, CHK_TEXT, CHK_ERROR} check_kind_t;

  typedef struct {
    logic [LEN_W-1:0]        len;
    logic [CFG_W-1:0]        lo;
    logic [CFG_W-1:0]        hi;
    logic signed [VAL_W-1:0] v;
    check_kind_t             kind;
    string                   text;
  } directed_row_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic signed [VAL_W-1:0] value;
  logic                    busy;
  logic                    strobe;
  logic [CHAR_W-1:0]       out_char;
  logic                    last;
  logic                    base_error;
  logic                    wr_en;
  logic [CFG_IDX_W-1:0]    wr_index;
  logic [CFG_W-1:0]        wr_data;

  logic [LEN_W-1:0] cur_len;
  logic [CFG_W-1:0] cur_lo;
  logic [CFG_W-1:0] cur_hi;

  char_item_t    expected_chars[$];
  directed_row_t directed_rows[$];

  int mismatches   = 0;
  int values_sent  = 0;
  int chars_seen   = 0;
  int bases_loaded = 0;
  int bad_bases    = 0;
  int cycle_count  = 0;

  signed_int_to_base_digits_core #(
    .MAX_BASE(MAX_BASE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .value(value),
    .busy(busy),
    .strobe(strobe),
    .out_char(out_char),
    .last(last),
    .base_error(base_error),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] digit_symbol(int idx);
    if (idx < 8) return cur_lo[8*idx +: 8];
    if (idx < SYM_COUNT) return cur_hi[8*(idx-8) +: 8];
    return '0;
  endfunction

  function automatic bit base_usable();
    int n;
    logic [CHAR_W-1:0] s;
    n = int'(cur_len);
    if (n < 2 || n > MAX_BASE) return 1'b0;
    for (int i = 0; i < n; i++) begin
      s = digit_symbol(i);
      if (s == 8'h00 || s == CHAR_PLUS || s == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        if (digit_symbol(j) == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_value(logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] mag;
    logic [VAL_W-1:0] rdx;
    int digits[32];
    int nd;
    if (!base_usable()) begin
      expected_chars.push_back('{ch: '0, last: 1'b1, err: 1'b1});
      return;
    end
    rdx = VAL_W'(cur_len);
    mag = v;
    if (v[VAL_W-1]) begin
      expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0, err: 1'b0});
      mag = '0 - v;
    end
    nd = 0;
    do begin
      digits[nd] = int'(mag % rdx);
      mag = mag / rdx;
      nd++;
    end while (mag != 0 && nd < 32);
    for (int k = nd - 1; k >= 0; k--) begin
      expected_chars.push_back('{ch: digit_symbol(digits[k]), last: (k == 0), err: 1'b0});
    end
  endfunction

  function automatic int idle_gap(bit allowed);
    if (!allowed || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  task automatic add_row(logic [LEN_W-1:0] len, logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi,
                         logic signed [VAL_W-1:0] v, check_kind_t kind, string text);
    directed_row_t row;
    row.len  = len;
    row.lo   = lo;
    row.hi   = hi;
    row.v    = v;
    row.kind = kind;
    row.text = text;
    directed_rows.push_back(row);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0 || busy);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_base(logic [LEN_W-1:0] len, logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = len;
    drain();
    write_reg(REG_BASE_LEN, len_word);
    write_reg(REG_SYMBOLS_LOW, lo);
    write_reg(REG_SYMBOLS_HIGH, hi);
    wr_en   <= 1'b0;
    cur_len = len;
    cur_lo  = lo;
    cur_hi  = hi;
    bases_loaded++;
    if (!base_usable()) bad_bases++;
  endtask

  task automatic send_value(logic signed [VAL_W-1:0] v, int gap);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    values_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [LEN_W-1:0]        len;
    logic [CFG_W-1:0]        lo;
    logic [CFG_W-1:0]        hi;
    logic signed [VAL_W-1:0] v;
    logic [CHAR_W-1:0]       syms[SYM_COUNT];
    logic [CHAR_W-1:0]       s;
    longint                  pw;
    bit                      clash;
    bit                      broken;
    int                      want_len;
    int                      radix;
    int                      i;
    int                      j;

    rst      = 1'b1;
    start    = 1'b0;
    value    = '0;
    wr_en    = 1'b0;
    wr_index = '0;
    wr_data  = '0;
    cur_len  = '0;
    cur_lo   = '0;
    cur_hi   = '0;

    add_row(0, 0, 0, 0, CHK_ERROR, "");
    add_row(0, 0, 0, -1, CHK_ERROR, "");
    add_row(10, DEC_LO, DEC_HI, 0, CHK_TEXT, "0");
    add_row(10, DEC_LO, DEC_HI, 32'sh7FFF_FFFF, CHK_TEXT, "2147483647");
    add_row(10, DEC_LO, DEC_HI, 32'sh8000_0000, CHK_TEXT, "-2147483648");
    add_row(10, DEC_LO, DEC_HI, -1, CHK_TEXT, "-1");
    add_row(10, DEC_LO, DEC_HI, 9, CHK_TEXT, "9");
    add_row(10, DEC_LO, DEC_HI, 10, CHK_TEXT, "10");
    add_row(2, BIN_LO, 0, 32'sh8000_0000, CHK_MODEL, "");
    add_row(2, BIN_LO, 0, 32'sh7FFF_FFFF, CHK_MODEL, "");
    add_row(2, BIN_LO, 0, -1, CHK_TEXT, "-1");
    add_row(16, DEC_LO, HEX_HI, 0, CHK_TEXT, "0");
    add_row(16, DEC_LO, HEX_HI, 32'sh7FFF_FFFF, CHK_TEXT, "7FFFFFFF");
    add_row(16, DEC_LO, HEX_HI, 32'sh8000_0000, CHK_TEXT, "-80000000");
    add_row(16, DEC_LO, HEX_HI, 32'hDEAD_BEEF, CHK_MODEL, "");
    add_row(1, DEC_LO, DEC_HI, 5, CHK_ERROR, "");
    add_row(17, DEC_LO, HEX_HI, 5, CHK_ERROR, "");
    add_row(31, DEC_LO, HEX_HI, -5, CHK_ERROR, "");
    add_row(10, 64'h3736_2B34_3332_3130, DEC_HI, 77, CHK_ERROR, "");
    add_row(10, DEC_LO, 64'h0000_0000_0000_2D38, 77, CHK_ERROR, "");
    add_row(16, DEC_LO, 64'h0045_4443_4241_3938, 77, CHK_ERROR, "");
    add_row(16, DEC_LO, 64'h4645_4433_4241_3938, 77, CHK_ERROR, "");
    // Symbols past the radix are junk here and must be ignored.
    add_row(3, 64'h0000_0000_2B7A_7978, 64'h2D2B_0000_2D2B_0000, -7, CHK_MODEL, "");
    add_row(12, DEC_LO, 64'h4645_4433_4241_3938, 123456, CHK_MODEL, "");

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].len != cur_len || directed_rows[r].lo != cur_lo ||
          directed_rows[r].hi != cur_hi) begin
        load_base(directed_rows[r].len, directed_rows[r].lo, directed_rows[r].hi);
      end
      case (directed_rows[r].kind)
        CHK_TEXT: begin
          for (i = 0; i < directed_rows[r].text.len(); i++) begin
            expected_chars.push_back('{ch: CHAR_W'(directed_rows[r].text[i]),
                                       last: (i == directed_rows[r].text.len() - 1),
                                       err: 1'b0});
          end
        end
        CHK_ERROR: expected_chars.push_back('{ch: '0, last: 1'b1, err: 1'b1});
        default: predict_value(directed_rows[r].v);
      endcase
      send_value(directed_rows[r].v, idle_gap(1'b1));
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) want_len = 2;
      else if (p == 1) want_len = MAX_BASE;
      else want_len = $urandom_range(2, MAX_BASE);
      broken = (p % 4 == 3);
      for (i = 0; i < SYM_COUNT; i++) syms[i] = CHAR_W'($urandom);
      for (i = 0; i < want_len; i++) begin
        do begin
          s = CHAR_W'($urandom);
          clash = (s == 8'h00 || s == CHAR_PLUS || s == CHAR_MINUS);
          for (j = 0; j < i; j++) begin
            if (syms[j] == s) clash = 1'b1;
          end
        end while (clash);
        syms[i] = s;
      end
      len = LEN_W'(want_len);
      if (broken) begin
        case ($urandom_range(0, 2))
          0: s = 8'h00;
          1: s = CHAR_PLUS;
          default: s = CHAR_MINUS;
        endcase
        case ($urandom_range(0, 3))
          0: len = LEN_W'($urandom_range(0, 1));
          1: len = LEN_W'($urandom_range(MAX_BASE + 1, 31));
          2: syms[$urandom_range(0, want_len - 1)] = s;
          default: begin
            i = $urandom_range(1, want_len - 1);
            j = $urandom_range(0, i - 1);
            syms[i] = syms[j];
          end
        endcase
      end
      for (i = 0; i < 8; i++) begin
        lo[8*i +: 8] = syms[i];
        hi[8*i +: 8] = syms[i+8];
      end
      load_base(len, lo, hi);
      radix = (len >= 2 && len <= MAX_BASE) ? int'(len) : 10;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) drain();
        case ($urandom_range(0, 5))
          0, 1: v = $urandom;
          2: v = $urandom_range(0, 2 * radix * radix);
          3: v = -int'($urandom_range(1, 300));
          4: begin
            case ($urandom_range(0, 3))
              0: v = 32'sh8000_0000;
              1: v = 32'sh7FFF_FFFF;
              2: v = 0;
              default: v = -1;
            endcase
          end
          default: begin
            pw = 1;
            repeat ($urandom_range(1, 31)) begin
              if (pw * radix < 64'h1_0000_0000) pw = pw * radix;
            end
            v = VAL_W'(pw - $urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) v = -v;
          end
        endcase
        predict_value(v);
        send_value(v, idle_gap(p % 3 != 1 && p < PHASES - 2));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d values through %0d base settings (%0d invalid), radix 2 to 16.",
             values_sent, bases_loaded, bad_bases);
    $display("Checked %0d characters, including both value extremes, zero and radix powers.",
             chars_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    char_item_t want;
    if (!rst && strobe !== 1'b0) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $display("%0t: character %h arrived with no value pending", $time, out_char);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch) begin
          $display("%0t: out_char expected %h, got %h", $time, want.ch, out_char);
          mismatches++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %b, got %b", $time, want.last, last);
          mismatches++;
        end
        if (base_error !== want.err) begin
          $display("%0t: base_error expected %b, got %b", $time, want.err, base_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
